// File: sv/nsfc_pkg.sv
// ----------------------------------------------------------------------------
// nsfc_pkg
// Shared types, codes and character helpers for the NMEA sentence framer
// and checksum checker.
// ----------------------------------------------------------------------------
package nsfc_pkg;

    // Default sentence length limit in stored characters
    localparam int MAX_LEN_DEFAULT = 128;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 8;
    localparam int KIND_W  = 3;

    // Event codes on the result channel
    typedef enum logic [KIND_W-1:0] {
        EV_START = 3'd0,
        EV_BODY  = 3'd1,
        EV_END   = 3'd2,
        EV_ACK   = 3'd3,
        EV_NACK  = 3'd4
    } event_kind_t;

    // Framing characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    // Acknowledge message prefix and class bytes
    localparam logic [BYTE_W-1:0] ACK_SYNC1 = 8'hB5;
    localparam logic [BYTE_W-1:0] ACK_SYNC2 = 8'h62;
    localparam logic [BYTE_W-1:0] ACK_CLASS = 8'h05;
    localparam logic [BYTE_W-1:0] ACK_NAK   = 8'h00;
    localparam logic [BYTE_W-1:0] ACK_ACK   = 8'h01;

    // Prefix match progress
    localparam logic [1:0] MATCH_IDLE  = 2'd0;
    localparam logic [1:0] MATCH_SYNC1 = 2'd1;
    localparam logic [1:0] MATCH_SYNC2 = 2'd2;
    localparam logic [1:0] MATCH_CLASS = 2'd3;

    // One accepted input beat
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              chunk_first;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        event_kind_t        kind;
        logic [BYTE_W-1:0]  ch;
        logic [COUNT_W-1:0] len;
        logic               ok;
    } result_t;

    // Characters kept inside a sentence: digits, capitals and $ - . * ,
    function automatic logic keep_char(input logic [BYTE_W-1:0] c);
        logic is_digit;
        logic is_upper;
        logic is_mark;
        is_digit = (c >= 8'h30) && (c <= 8'h39);
        is_upper = (c >= 8'h41) && (c <= 8'h5A);
        is_mark  = (c == CH_DOLLAR) || (c == 8'h2D) || (c == 8'h2E) ||
                   (c == CH_STAR) || (c == 8'h2C);
        return is_digit || is_upper || is_mark;
    endfunction

    // Hex digit decode: 0-9 and A-F, bad flags anything else
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        logic              bad;
        d   = '0;
        bad = 1'b0;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            d = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            d = c - 8'h37;
        end
        else
        begin
            bad = 1'b1;
        end
        return {bad, d[3:0]};
    endfunction

endpackage

// File: sv/nmea_sentence_framer_checker_unit.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker_unit
// Frames NMEA sentences from a received byte stream, checks the XOR
// checksum and reports acknowledge / negative-acknowledge messages.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall   data_byte, chunk_first
//   out      output     out_valid / out_stall event_kind, out_byte,
//                                             sentence_length, checksum_ok
//
// One byte per cycle sustained while the output is not stalled; a byte's
// result is presented from the result register, after the input register.
// Bytes that cause no result still take their slot in the core stage.
// Reset clears all framing, checksum and match state.
// A stalled output holds the result register and backs up into in_stall
// only once the input register is also full.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker_unit
    import nsfc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               chunk_first,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  event_kind,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [COUNT_W-1:0] sentence_length,
    output logic               checksum_ok
);

    logic     advance;
    logic     beat_valid;
    in_beat_t beat;
    logic     fire;
    logic     res_valid;
    result_t  res;

    // Process the held beat when the result register can take it
    assign fire = beat_valid && advance;

    nsfc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .data_byte   (data_byte),
        .chunk_first (chunk_first),
        .advance     (advance),
        .in_stall    (in_stall),
        .beat_valid  (beat_valid),
        .beat        (beat)
    );

    nsfc_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    nsfc_out_stage u_out_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .res_valid       (res_valid),
        .res             (res),
        .out_stall       (out_stall),
        .advance         (advance),
        .out_valid       (out_valid),
        .event_kind      (event_kind),
        .out_byte        (out_byte),
        .sentence_length (sentence_length),
        .checksum_ok     (checksum_ok)
    );

endmodule

// File: sv/nsfc_in_stage.sv
// ----------------------------------------------------------------------------
// nsfc_in_stage
// Input register: captures one byte beat and holds it until the core
// stage advances.
// ----------------------------------------------------------------------------
module nsfc_in_stage
    import nsfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              chunk_first,
    input  logic              advance,
    output logic              in_stall,
    output logic              beat_valid,
    output in_beat_t          beat
);

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;
    logic     load;

    // Hold the beat while the downstream stage cannot take it
    assign in_stall   = valid_reg && !advance;
    assign load       = !in_stall;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            beat_reg.data_byte   <= data_byte;
            beat_reg.chunk_first <= chunk_first;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// File: sv/nsfc_core.sv
// ----------------------------------------------------------------------------
// nsfc_core
// Framing and checksum state: decodes one byte per cycle unless stalled,
// updates the sentence and acknowledge-match state and forms at most one result.
// ----------------------------------------------------------------------------
module nsfc_core
    import nsfc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  in_beat_t beat,
    output logic     res_valid,
    output result_t  res
);

    localparam logic [COUNT_W-1:0] LEN_LIMIT = COUNT_W'(MAX_LEN);

    logic               in_sentence_reg,  in_sentence_next;
    logic [COUNT_W-1:0] count_reg,        count_next;
    logic [BYTE_W-1:0]  xor_reg,          xor_next;
    logic               star_reg,         star_next;
    logic [1:0]         taken_reg,        taken_next;
    logic [BYTE_W-1:0]  rx_sum_reg,       rx_sum_next;
    logic               digit_err_reg,    digit_err_next;
    logic [1:0]         match_reg,        match_next;
    logic               skip_reg,         skip_next;

    logic [BYTE_W-1:0]  c;
    logic [1:0]         match_cur;
    logic               skip_cur;
    logic               check_ok;
    logic [4:0]         hex;

    assign c   = beat.data_byte;
    assign hex = hex_digit(c);

    // Checksum verdict from the state before this byte
    assign check_ok = star_reg && (taken_reg == 2'd2) && !digit_err_reg &&
                      (rx_sum_reg == xor_reg);

    // Decode one byte
    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        count_next       = count_reg;
        xor_next         = xor_reg;
        star_next        = star_reg;
        taken_next       = taken_reg;
        rx_sum_next      = rx_sum_reg;
        digit_err_next   = digit_err_reg;
        res_valid        = 1'b0;
        res.kind         = EV_BODY;
        res.ch           = '0;
        res.len          = count_reg;
        res.ok           = 1'b0;

        // Clear the chunk-scoped state on a new chunk
        match_cur = beat.chunk_first ? MATCH_IDLE : match_reg;
        skip_cur  = beat.chunk_first ? 1'b0 : skip_reg;
        match_next = match_cur;
        skip_next  = skip_cur;

        if (!skip_cur)
        begin
            priority if ((match_cur == MATCH_IDLE) && (c == ACK_SYNC1))
            begin
                match_next = MATCH_SYNC1;
            end
            else if ((match_cur == MATCH_SYNC1) && (c == ACK_SYNC2))
            begin
                match_next = MATCH_SYNC2;
            end
            else if ((match_cur == MATCH_SYNC2) && (c == ACK_CLASS))
            begin
                match_next = MATCH_CLASS;
            end
            else if ((match_cur == MATCH_CLASS) && ((c == ACK_NAK) || (c == ACK_ACK)))
            begin
                // Report and drop the rest of the chunk
                skip_next = 1'b1;
                res_valid = 1'b1;
                res.kind  = (c == ACK_ACK) ? EV_ACK : EV_NACK;
            end
            else if (c == CH_DOLLAR)
            begin
                // Start a new sentence
                in_sentence_next = 1'b1;
                count_next       = COUNT_W'(1);
                xor_next         = '0;
                star_next        = 1'b0;
                taken_next       = '0;
                rx_sum_next      = '0;
                digit_err_next   = 1'b0;
                res_valid        = 1'b1;
                res.kind         = EV_START;
                res.ch           = c;
                res.len          = COUNT_W'(1);
            end
            else if (!in_sentence_reg)
            begin
                // Ignore bytes between sentences
            end
            else if (count_reg >= LEN_LIMIT)
            begin
                // Close on overrun, drop the byte
                in_sentence_next = 1'b0;
                res_valid        = 1'b1;
                res.kind         = EV_END;
                res.ok           = check_ok;
            end
            else if (c == CH_CR)
            begin
                // Close on carriage return, counted as stored
                in_sentence_next = 1'b0;
                count_next       = count_reg + COUNT_W'(1);
                res_valid        = 1'b1;
                res.kind         = EV_END;
                res.len          = count_reg + COUNT_W'(1);
                res.ok           = check_ok;
            end
            else if (keep_char(c))
            begin
                count_next = count_reg + COUNT_W'(1);
                res_valid  = 1'b1;
                res.kind   = EV_BODY;
                res.ch     = c;
                res.len    = count_reg + COUNT_W'(1);
                // Accumulate XOR up to '*', then take two hex digits
                if (!star_reg)
                begin
                    if (c == CH_STAR)
                    begin
                        star_next = 1'b1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ c;
                    end
                end
                else if (taken_reg != 2'd2)
                begin
                    rx_sum_next = {rx_sum_reg[3:0], hex[3:0]};
                    taken_next  = taken_reg + 2'd1;
                    if (hex[4])
                    begin
                        digit_err_next = 1'b1;
                    end
                end
            end
            else
            begin
                // Drop characters outside the sentence alphabet
            end
        end
    end

    // Advance state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            count_reg       <= '0;
            xor_reg         <= '0;
            star_reg        <= 1'b0;
            taken_reg       <= '0;
            rx_sum_reg      <= '0;
            digit_err_reg   <= 1'b0;
            match_reg       <= MATCH_IDLE;
            skip_reg        <= 1'b0;
        end
        else if (fire)
        begin
            in_sentence_reg <= in_sentence_next;
            count_reg       <= count_next;
            xor_reg         <= xor_next;
            star_reg        <= star_next;
            taken_reg       <= taken_next;
            rx_sum_reg      <= rx_sum_next;
            digit_err_reg   <= digit_err_next;
            match_reg       <= match_next;
            skip_reg        <= skip_next;
        end
    end

endmodule

// File: sv/nsfc_out_stage.sv
// ----------------------------------------------------------------------------
// nsfc_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module nsfc_out_stage
    import nsfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               res_valid,
    input  result_t            res,
    input  logic               out_stall,
    output logic               advance,
    output logic               out_valid,
    output logic [KIND_W-1:0]  event_kind,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [COUNT_W-1:0] sentence_length,
    output logic               checksum_ok
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Move on when the register is empty or being drained
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? (fire && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result beat
    always_ff @(posedge clk)
    begin
        if (advance && fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = valid_reg;
    assign event_kind      = res_reg.kind;
    assign out_byte        = res_reg.ch;
    assign sentence_length = res_reg.len;
    assign checksum_ok     = res_reg.ok;

endmodule
